FILE: rtl/core/gated_nearest_track_association_core_assert.svh
// Assertion macros shared by the track association core modules.
// Expects signals named clk and rst in the module that uses them.
`ifndef GATED_NEAREST_TRACK_ASSOCIATION_CORE_ASSERT_SVH
`define GATED_NEAREST_TRACK_ASSOCIATION_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GNTA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GNTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gnta_pkg.sv
// Shared constants and types for the gated nearest track association core.
// No dependencies; used by gnta_ctrl, gnta_dp and the top level.
`timescale 1ns / 1ps

package gnta_pkg;

  localparam int MAX_TRACKS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam int CMD_W      = 2;
  localparam int FRAME_W    = 16;
  localparam int ID_W       = 15;
  localparam int POS_W      = 16;
  localparam int TRACK_ID_W = 16;
  localparam int GATE_W     = 33;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;

  localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(625);
  localparam logic [TRACK_ID_W-1:0] NO_TRACK = '1;

  // Input command codes
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Register select: paddr bit 3 picks the 64-bit register slot
  localparam logic REG_GATE = 1'b0;

  typedef struct packed {
    logic clear_frame;
    logic load_track;
    logic start_query;
    logic issue_read;
    logic finish;
  } gnta_cmd_t;

  typedef struct packed {
    logic store_empty;
    logic last_read;
    logic pipe_empty;
    logic out_free;
  } gnta_sts_t;

endpackage

FILE: rtl/core/gnta_ctrl.sv
// Controller for the track association core: decodes input commands and
// sequences the track scan. Depends on gnta_pkg and the assertion header.
`timescale 1ns / 1ps
`include "gated_nearest_track_association_core_assert.svh"

module gnta_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gnta_pkg::CMD_W-1:0] cmd,
  input  gnta_pkg::gnta_sts_t        sts,
  output gnta_pkg::gnta_cmd_t        ctl
);
  import gnta_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd)
            CMD_START: ctl.clear_frame = 1'b1;
            CMD_LOAD:  ctl.load_track  = 1'b1;
            CMD_QUERY: begin
              ctl.start_query = 1'b1;
              state_next      = sts.store_empty ? ST_FINISH : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        ctl.issue_read = 1'b1;
        if (sts.last_read) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `GNTA_ASSERT_IMPL(a_finish_needs_drain, ctl.finish, sts.pipe_empty && sts.out_free,
                    "result issued before the scan pipeline drained")
  `GNTA_ASSERT_IMPL(a_no_accept_in_scan, ctl.issue_read, !in_ready && !ctl.start_query,
                    "input accepted while a scan is running")
  `GNTA_ASSERT_NEXT(a_empty_query_skips_scan, ctl.start_query && sts.store_empty,
                    state == ST_FINISH, "query on empty store entered the scan")

endmodule

FILE: rtl/core/gnta_dp.sv
// Datapath for the track association core: track store, distance pipeline,
// nearest-track tracking and result register. Depends on gnta_pkg.
`timescale 1ns / 1ps
`include "gated_nearest_track_association_core_assert.svh"

module gnta_dp #(
  parameter int MAX_TRACKS = gnta_pkg::MAX_TRACKS_DEF,
  parameter int COORD_BITS = gnta_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  gnta_pkg::gnta_cmd_t                    ctl,
  output gnta_pkg::gnta_sts_t                    sts,
  input  logic [gnta_pkg::FRAME_W-1:0]           frame_number,
  input  logic [gnta_pkg::ID_W-1:0]              item_id,
  input  logic signed [gnta_pkg::POS_W-1:0]      pos_x,
  input  logic signed [gnta_pkg::POS_W-1:0]      pos_y,
  input  logic [gnta_pkg::GATE_W-1:0]            gate,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [gnta_pkg::ID_W-1:0]              object_id,
  output logic [gnta_pkg::FRAME_W-1:0]           result_frame,
  output logic signed [gnta_pkg::TRACK_ID_W-1:0] track_id,
  output logic [gnta_pkg::GATE_W-1:0]            best_distance,
  output logic                                   store_overflowed
);
  import gnta_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int AW     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TRACKS + 1);
  localparam int DIST_W = 2 * CW + 1;
  localparam int CMP_W  = (DIST_W > GATE_W) ? DIST_W : GATE_W;
  localparam int ENT_W  = ID_W + 2 * CW;

  // Frame and store control
  logic [CNT_W-1:0]   track_count;
  logic [FRAME_W-1:0] cur_frame;
  logic               ovf;
  logic               full;

  // Scan control
  logic [CNT_W-1:0] rd_cnt;
  logic             v1;
  logic             v2;
  logic             v3;
  logic             found;

  // Track store
  logic [ENT_W-1:0] trk_mem [MAX_TRACKS];
  logic [ENT_W-1:0] rd_data;

  // Query and pipeline payload
  logic [CW-1:0]     in_x;
  logic [CW-1:0]     in_y;
  logic [CW-1:0]     qx;
  logic [CW-1:0]     qy;
  logic [ID_W-1:0]   qid;
  logic [ID_W-1:0]   rd_id;
  logic [CW-1:0]     rd_x;
  logic [CW-1:0]     rd_y;
  logic [CW:0]       diff_x;
  logic [CW:0]       diff_y;
  logic [CW:0]       neg_x;
  logic [CW:0]       neg_y;
  logic [CW-1:0]     abs_x;
  logic [CW-1:0]     abs_y;
  logic [CW-1:0]     s2_dx;
  logic [CW-1:0]     s2_dy;
  logic [ID_W-1:0]   s2_id;
  logic [2*CW-1:0]   sq_x;
  logic [2*CW-1:0]   sq_y;
  logic [2*CW-1:0]   s3_sqx;
  logic [2*CW-1:0]   s3_sqy;
  logic [ID_W-1:0]   s3_id;
  logic [DIST_W-1:0] dist_sum;
  logic              upd;
  logic [DIST_W-1:0] best;
  logic [ID_W-1:0]   best_id;
  logic              in_gate;

  // Low COORD_BITS of the position field, sign taken from the top kept bit
  assign in_x = CW'($unsigned(pos_x));
  assign in_y = CW'($unsigned(pos_y));

  assign full = (track_count == CNT_W'(MAX_TRACKS));

  always_ff @(posedge clk) begin
    if (ctl.load_track && !full) begin
      trk_mem[track_count[AW-1:0]] <= {item_id, in_x, in_y};
    end
    if (ctl.issue_read) begin
      rd_data <= trk_mem[rd_cnt[AW-1:0]];
    end
  end

  // Stage 1: absolute coordinate differences
  assign rd_id  = rd_data[ENT_W-1 -: ID_W];
  assign rd_x   = rd_data[2*CW-1 -: CW];
  assign rd_y   = rd_data[CW-1:0];
  assign diff_x = {qx[CW-1], qx} - {rd_x[CW-1], rd_x};
  assign diff_y = {qy[CW-1], qy} - {rd_y[CW-1], rd_y};
  assign neg_x  = (CW + 1)'(0) - diff_x;
  assign neg_y  = (CW + 1)'(0) - diff_y;
  assign abs_x  = diff_x[CW] ? neg_x[CW-1:0] : diff_x[CW-1:0];
  assign abs_y  = diff_y[CW] ? neg_y[CW-1:0] : diff_y[CW-1:0];

  // Stage 2: squares
  assign sq_x = s2_dx * s2_dx;
  assign sq_y = s2_dy * s2_dy;

  // Stage 3: sum and running minimum, first loaded wins a tie
  assign dist_sum = {1'b0, s3_sqx} + {1'b0, s3_sqy};
  assign upd      = v3 && (!found || (dist_sum < best));

  assign in_gate = (CMP_W'(best) <= CMP_W'(gate));

  always_ff @(posedge clk) begin
    if (rst) begin
      track_count <= '0;
      cur_frame   <= '0;
      ovf         <= 1'b0;
      rd_cnt      <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (ctl.clear_frame) begin
        track_count <= '0;
        ovf         <= 1'b0;
        cur_frame   <= frame_number;
      end
      if (ctl.load_track) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          track_count <= track_count + CNT_W'(1);
        end
      end
      if (ctl.start_query) begin
        rd_cnt <= '0;
        found  <= 1'b0;
      end else if (ctl.issue_read) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
      v1 <= ctl.issue_read;
      v2 <= v1;
      v3 <= v2;
      if (upd) begin
        found <= 1'b1;
      end
      if (ctl.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start_query) begin
      qx   <= in_x;
      qy   <= in_y;
      qid  <= item_id;
      best <= '0;
    end
    if (v1) begin
      s2_dx <= abs_x;
      s2_dy <= abs_y;
      s2_id <= rd_id;
    end
    if (v2) begin
      s3_sqx <= sq_x;
      s3_sqy <= sq_y;
      s3_id  <= s2_id;
    end
    if (upd) begin
      best    <= dist_sum;
      best_id <= s3_id;
    end
    if (ctl.finish) begin
      object_id        <= qid;
      result_frame     <= cur_frame;
      track_id         <= (found && in_gate) ? TRACK_ID_W'(best_id) : NO_TRACK;
      best_distance    <= GATE_W'(best);
      store_overflowed <= ovf;
    end
  end

  assign sts.store_empty = (track_count == '0);
  assign sts.last_read   = ((rd_cnt + CNT_W'(1)) == track_count);
  assign sts.pipe_empty  = !v1 && !v2 && !v3;
  assign sts.out_free    = !out_valid || out_ready;

  `GNTA_ASSERT_IMPL(a_read_in_range, ctl.issue_read, rd_cnt < track_count,
                    "scan read past the loaded tracks")
  `GNTA_ASSERT_IMPL(a_query_on_idle_pipe, ctl.start_query, !v1 && !v2 && !v3,
                    "query started with the distance pipeline busy")
  `GNTA_ASSERT_NEXT(a_full_load_dropped, ctl.load_track && full,
                    ovf && $stable(track_count), "load into a full store not dropped")

endmodule

FILE: rtl/core/gated_nearest_track_association_core.sv
// Top level of the gated nearest track association core: register port,
// controller and datapath. Depends on gnta_pkg, gnta_ctrl and gnta_dp.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    cmd, frame_number, item_id, pos_x, pos_y
//   out      output     out_valid / out_ready  object_id, result_frame, track_id,
//                                              best_distance, store_overflowed
//   cfg      input      psel/penable/pwrite    paddr, pwdata, prdata (gate register)
//
// A query reads one track per cycle through the single read port of the track
// store, then the distance pipeline drains; on an empty store the scan is skipped.
// Reset is synchronous; the track store needs no clearing pass, only its count resets.
// Input is held off during a scan and while a finished result waits for a full
// output register; start and load transactions pass while a result is pending.
`timescale 1ns / 1ps

module gated_nearest_track_association_core #(
  parameter int MAX_TRACKS = gnta_pkg::MAX_TRACKS_DEF,
  parameter int COORD_BITS = gnta_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [gnta_pkg::CMD_W-1:0]             cmd,
  input  logic [gnta_pkg::FRAME_W-1:0]           frame_number,
  input  logic [gnta_pkg::ID_W-1:0]              item_id,
  input  logic signed [gnta_pkg::POS_W-1:0]      pos_x,
  input  logic signed [gnta_pkg::POS_W-1:0]      pos_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [gnta_pkg::ID_W-1:0]              object_id,
  output logic [gnta_pkg::FRAME_W-1:0]           result_frame,
  output logic signed [gnta_pkg::TRACK_ID_W-1:0] track_id,
  output logic [gnta_pkg::GATE_W-1:0]            best_distance,
  output logic                                   store_overflowed,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [gnta_pkg::PADDR_W-1:0]           paddr,
  input  logic [gnta_pkg::PDATA_W-1:0]           pwdata,
  output logic [gnta_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready
);
  import gnta_pkg::*;

  logic [GATE_W-1:0] gate;
  gnta_cmd_t         ctl;
  gnta_sts_t         sts;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_GATE) ? PDATA_W'(gate) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate <= GATE_RESET;
    end else if (psel && penable && pwrite && (paddr[3] == REG_GATE)) begin
      gate <= pwdata[GATE_W-1:0];
    end
  end

  gnta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts),
    .ctl      (ctl)
  );

  gnta_dp #(
    .MAX_TRACKS (MAX_TRACKS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .sts              (sts),
    .frame_number     (frame_number),
    .item_id          (item_id),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .gate             (gate),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .object_id        (object_id),
    .result_frame     (result_frame),
    .track_id         (track_id),
    .best_distance    (best_distance),
    .store_overflowed (store_overflowed)
  );

endmodule
